/* rtl/core/esc_pkg.sv */
// esc_pkg: shared constants, tables and types for the epoch-seconds to calendar pipeline.
// No dependencies; used by esc_pipe_ctrl, epoch_seconds_to_calendar and the bench.
package esc_pkg;

   localparam int SECONDS_WIDTH_DEFAULT = 34;

   // 86400 = 128 * 675: the low seven bits of the count bypass the day divide
   localparam int SUB_DAY_LOW_W  = 7;
   localparam int DAY_DIV_ODD    = 675;
   localparam int DAY_DIV_ODD_W  = 10;
   localparam int HIGH_PART_W    = 16;
   localparam int HIGH_QUOT_W    = 7;
   localparam int TOD_W          = 17;

   localparam int SECS_PER_HOUR  = 3600;
   localparam int SECS_PER_MIN   = 60;
   localparam int DAYS_PER_WEEK  = 7;

   localparam int DAYS_PER_400Y  = 146097;
   localparam int DAYS_PER_100Y  = 36524;
   localparam int DAYS_PER_4Y    = 1461;
   localparam int DAYS_PER_YEAR  = 365;
   localparam int DAYS_1601_TO_1970 = 134774;

   localparam int YEARS_PER_400Y = 400;
   localparam int YEARS_PER_100Y = 100;
   localparam int YEARS_PER_4Y   = 4;
   localparam int YEAR_1601_TO_1900 = 299;

   // last block index that may be clamped (century in cycle, year in 4-year block)
   localparam int BLOCK_LAST     = 3;
   localparam int Q4_LAST_OF_CENTURY = 24;

   localparam int MONTHS         = 12;
   localparam int STAGES         = 15;

   localparam int SECOND_W       = 6;
   localparam int MINUTE_W       = 6;
   localparam int HOUR_W         = 5;
   localparam int MDAY_W         = 5;
   localparam int MONTH_W        = 4;
   localparam int YEAR_W         = 10;
   localparam int WEEKDAY_W      = 3;
   localparam int DOY_W          = 9;

   localparam logic [WEEKDAY_W-1:0] WEEKDAY_SATURDAY = 3'd6;

   // first day of each month within the year, common and leap
   localparam logic [DOY_W-1:0] MONTH_START [2][MONTHS] = '{
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
   };

   typedef struct packed {
      logic [HOUR_W-1:0]    hour;
      logic [MINUTE_W-1:0]  minute;
      logic [SECOND_W-1:0]  second;
      logic [WEEKDAY_W-1:0] weekday;
   } side_type;

endpackage

/* rtl/core/esc_cdiv.sv */
// esc_cdiv: two-stage divide by a constant (reciprocal multiply, then one correction step),
// with an optional clamp of the quotient. Depends on nothing; instanced by the top level.
module esc_cdiv #(
   parameter int IN_W    = 16,
   parameter int DIVISOR = 675,
   parameter int Q_W     = 7,
   parameter int R_W     = 10,
   parameter int QMAX    = (1 << Q_W) - 1
) (
   input  logic            clock,
   input  logic            load_a,
   input  logic            load_b,
   input  logic [IN_W-1:0] x,
   output logic [Q_W-1:0]  q,
   output logic [R_W-1:0]  r
);

   localparam longint unsigned RECIP = (64'd1 << IN_W) / DIVISOR;
   localparam int RECIP_W = $clog2(RECIP + 64'd1);
   localparam int P_W = IN_W + RECIP_W;
   localparam longint unsigned CLAMP_AT = (64'(QMAX) + 64'd1) * 64'(DIVISOR);
   localparam longint unsigned CLAMP_BASE = 64'(QMAX) * 64'(DIVISOR);

   logic [P_W-1:0]  prod;
   logic [IN_W-1:0] x_ff;
   logic [Q_W-1:0]  qe_ff, qe_in;
   logic            top_ff, top_in;
   logic [IN_W-1:0] r_full;
   logic            fix;
   logic [Q_W-1:0]  q_ff, q_in;
   logic [R_W-1:0]  r_ff, r_in;

   // estimate is low by at most one since x < 2**IN_W
   assign prod   = P_W'(x) * P_W'(RECIP);
   assign qe_in  = Q_W'(prod >> IN_W);
   assign top_in = 64'(x) >= CLAMP_AT;

   always_ff @(posedge clock) begin
      if (load_a) begin
         x_ff   <= x;
         qe_ff  <= qe_in;
         top_ff <= top_in;
      end
   end

   assign r_full = x_ff - IN_W'(64'(qe_ff) * 64'(DIVISOR));
   assign fix    = r_full >= IN_W'(DIVISOR);

   always_comb begin
      if (top_ff) begin
         q_in = Q_W'(QMAX);
         r_in = R_W'(x_ff - IN_W'(CLAMP_BASE));
      end else if (fix) begin
         q_in = qe_ff + Q_W'(1);
         r_in = R_W'(r_full - IN_W'(DIVISOR));
      end else begin
         q_in = qe_ff;
         r_in = R_W'(r_full);
      end
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign q = q_ff;
   assign r = r_ff;

endmodule

/* rtl/core/esc_pipe_ctrl.sv */
// esc_pipe_ctrl: valid bits and per-stage load enables for the conversion pipeline.
// Depends on esc_pkg for the default stage count.
module esc_pipe_ctrl #(
   parameter int STAGES = esc_pkg::STAGES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_stall,
   output logic              req_stall,
   output logic              rsp_valid,
   output logic [STAGES-1:0] load
);

   logic [STAGES-1:0] valid_ff, valid_in;

   // a stage loads when it is empty or its successor loads, so bubbles fill
   always_comb begin
      load[STAGES-1] = ~valid_ff[STAGES-1] | ~rsp_stall;
      for (int s = STAGES - 2; s >= 0; s--) begin
         load[s] = ~valid_ff[s] | load[s+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = load[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = ~load[0];
   assign rsp_valid = valid_ff[STAGES-1];

endmodule

/* rtl/core/epoch_seconds_to_calendar.sv */
// epoch_seconds_to_calendar: top level, seconds since 1970 to broken-down Gregorian time.
// Depends on esc_pkg, esc_cdiv and esc_pipe_ctrl.
//
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 into second, minute,
// hour, day of month (1 to 31), month (0 is January), years since 1900 and weekday
// (0 is Sunday).
// The block accepts one transaction every cycle while the result side does not stall.
// The pipeline is the chain of constant dividers (days, 400-year, 100-year, 4-year and
// 1-year blocks), each a reciprocal multiply stage followed by a correction stage, plus
// the month lookup.
// Stalls on the result side back up the pipeline stage by stage; empty stages still fill.
// Input bits are taken as given at SECONDS_WIDTH bits; years_since_1900 wraps modulo 1024
// for widths above 34.
module epoch_seconds_to_calendar #(
   parameter int SECONDS_WIDTH = esc_pkg::SECONDS_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [SECONDS_WIDTH-1:0]        req_epoch_seconds,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [esc_pkg::SECOND_W-1:0]    rsp_second,
   output logic [esc_pkg::MINUTE_W-1:0]    rsp_minute,
   output logic [esc_pkg::HOUR_W-1:0]      rsp_hour,
   output logic [esc_pkg::MDAY_W-1:0]      rsp_day_of_month,
   output logic [esc_pkg::MONTH_W-1:0]     rsp_month_index,
   output logic [esc_pkg::YEAR_W-1:0]      rsp_years_since_1900,
   output logic [esc_pkg::WEEKDAY_W-1:0]   rsp_weekday
);

   localparam int LOW_W  = esc_pkg::SUB_DAY_LOW_W;
   localparam int HI_W   = esc_pkg::HIGH_PART_W;
   localparam int XL_W   = SECONDS_WIDTH - LOW_W - HI_W;
   localparam int Q1_W   = esc_pkg::HIGH_QUOT_W;
   localparam int ODD_W  = esc_pkg::DAY_DIV_ODD_W;
   localparam int DAYS_W = Q1_W + XL_W;
   localparam int OFS_W  = $clog2(esc_pkg::DAYS_1601_TO_1970 + 1);
   localparam int D0_W   = ((DAYS_W > OFS_W) ? DAYS_W : OFS_W) + 1;
   localparam int Q400_W = D0_W - 17;
   localparam int R400_W = 18;
   localparam int R100_W = 16;
   localparam int R4_W   = 11;
   localparam int TOD_W  = esc_pkg::TOD_W;
   localparam int RH_W   = 12;
   localparam int YW     = esc_pkg::YEAR_W;

   logic [esc_pkg::STAGES-1:0] load;

   esc_pipe_ctrl #(
      .STAGES(esc_pkg::STAGES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .rsp_stall(rsp_stall),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .load     (load)
   );

   // ---- day count: (secs >> 7) / 675 in two long-division digits ----
   logic [Q1_W-1:0]  a_q;
   logic [ODD_W-1:0] a_r;
   logic [XL_W-1:0]  b_q;
   logic [ODD_W-1:0] b_r;
   logic [XL_W-1:0]  xl_ff [0:1];
   logic [LOW_W-1:0] low_ff [0:3];
   logic [Q1_W-1:0]  q1_ff [2:3];

   esc_cdiv #(
      .IN_W(HI_W), .DIVISOR(esc_pkg::DAY_DIV_ODD), .Q_W(Q1_W), .R_W(ODD_W)
   ) u_div_hi (
      .clock(clock), .load_a(load[0]), .load_b(load[1]),
      .x(req_epoch_seconds[SECONDS_WIDTH-1 -: HI_W]), .q(a_q), .r(a_r)
   );

   esc_cdiv #(
      .IN_W(ODD_W + XL_W), .DIVISOR(esc_pkg::DAY_DIV_ODD), .Q_W(XL_W), .R_W(ODD_W)
   ) u_div_lo (
      .clock(clock), .load_a(load[2]), .load_b(load[3]),
      .x({a_r, xl_ff[1]}), .q(b_q), .r(b_r)
   );

   always_ff @(posedge clock) begin
      if (load[0]) begin
         xl_ff[0]  <= req_epoch_seconds[LOW_W +: XL_W];
         low_ff[0] <= req_epoch_seconds[LOW_W-1:0];
      end
      if (load[1]) begin
         xl_ff[1]  <= xl_ff[0];
         low_ff[1] <= low_ff[0];
      end
      if (load[2]) begin
         q1_ff[2]  <= a_q;
         low_ff[2] <= low_ff[1];
      end
      if (load[3]) begin
         q1_ff[3]  <= q1_ff[2];
         low_ff[3] <= low_ff[2];
      end
   end

   // ---- day number since 1601-01-01 ----
   logic [D0_W-1:0] d0_ff, d0_in;

   assign d0_in = D0_W'({q1_ff[3], b_q}) + D0_W'(esc_pkg::DAYS_1601_TO_1970);

   always_ff @(posedge clock) begin
      if (load[4]) begin
         d0_ff <= d0_in;
      end
   end

   // ---- time of day ----
   logic [esc_pkg::HOUR_W-1:0]   t_q;
   logic [RH_W-1:0]              t_r;
   logic [esc_pkg::MINUTE_W-1:0] m_q;
   logic [5:0]                   m_r;

   esc_cdiv #(
      .IN_W(TOD_W), .DIVISOR(esc_pkg::SECS_PER_HOUR), .Q_W(esc_pkg::HOUR_W), .R_W(RH_W)
   ) u_div_hour (
      .clock(clock), .load_a(load[4]), .load_b(load[5]),
      .x({b_r, low_ff[3]}), .q(t_q), .r(t_r)
   );

   esc_cdiv #(
      .IN_W(RH_W), .DIVISOR(esc_pkg::SECS_PER_MIN), .Q_W(esc_pkg::MINUTE_W), .R_W(6)
   ) u_div_min (
      .clock(clock), .load_a(load[6]), .load_b(load[7]),
      .x(t_r), .q(m_q), .r(m_r)
   );

   // ---- weekday: 1601-01-01 was a Monday, so weekday = (d0 + 1) mod 7 ----
   logic [esc_pkg::WEEKDAY_W-1:0] w_r;
   logic [esc_pkg::WEEKDAY_W-1:0] wd7_ff, wd7_in;

   esc_cdiv #(
      .IN_W(D0_W), .DIVISOR(esc_pkg::DAYS_PER_WEEK), .Q_W(D0_W - 2),
      .R_W(esc_pkg::WEEKDAY_W)
   ) u_div_week (
      .clock(clock), .load_a(load[5]), .load_b(load[6]),
      .x(d0_ff), .q(), .r(w_r)
   );

   assign wd7_in = (w_r == esc_pkg::WEEKDAY_SATURDAY) ? '0 : w_r + 3'd1;

   // ---- Gregorian blocks ----
   logic [Q400_W-1:0] c_q;
   logic [R400_W-1:0] c_r;
   logic [1:0]        h_q;
   logic [R100_W-1:0] h_r;
   logic [4:0]        f_q;
   logic [R4_W-1:0]   f_r;
   logic [1:0]        y_q;
   logic [esc_pkg::DOY_W-1:0] y_r;

   esc_cdiv #(
      .IN_W(D0_W), .DIVISOR(esc_pkg::DAYS_PER_400Y), .Q_W(Q400_W), .R_W(R400_W)
   ) u_div_400 (
      .clock(clock), .load_a(load[5]), .load_b(load[6]),
      .x(d0_ff), .q(c_q), .r(c_r)
   );

   esc_cdiv #(
      .IN_W(R400_W), .DIVISOR(esc_pkg::DAYS_PER_100Y), .Q_W(2), .R_W(R100_W),
      .QMAX(esc_pkg::BLOCK_LAST)
   ) u_div_100 (
      .clock(clock), .load_a(load[7]), .load_b(load[8]),
      .x(c_r), .q(h_q), .r(h_r)
   );

   esc_cdiv #(
      .IN_W(R100_W), .DIVISOR(esc_pkg::DAYS_PER_4Y), .Q_W(5), .R_W(R4_W)
   ) u_div_4 (
      .clock(clock), .load_a(load[9]), .load_b(load[10]),
      .x(h_r), .q(f_q), .r(f_r)
   );

   esc_cdiv #(
      .IN_W(R4_W), .DIVISOR(esc_pkg::DAYS_PER_YEAR), .Q_W(2), .R_W(esc_pkg::DOY_W),
      .QMAX(esc_pkg::BLOCK_LAST)
   ) u_div_1 (
      .clock(clock), .load_a(load[11]), .load_b(load[12]),
      .x(f_r), .q(y_q), .r(y_r)
   );

   // ---- delay lines ----
   logic [esc_pkg::HOUR_W-1:0] hour_ff [6:7];
   esc_pkg::side_type          side_ff [8:13];
   esc_pkg::side_type          side_in;
   logic [Q400_W-1:0]          q400_ff [7:12];
   logic [1:0]                 c100_ff [9:12];
   logic [4:0]                 q4_ff   [11:12];

   assign side_in.hour    = hour_ff[7];
   assign side_in.minute  = m_q;
   assign side_in.second  = m_r;
   assign side_in.weekday = wd7_ff;

   always_ff @(posedge clock) begin
      if (load[6]) hour_ff[6] <= t_q;
      if (load[7]) begin
         hour_ff[7] <= hour_ff[6];
         wd7_ff     <= wd7_in;
         q400_ff[7] <= c_q;
      end
      if (load[8]) side_ff[8] <= side_in;
      for (int s = 9; s <= 13; s++) begin
         if (load[s]) side_ff[s] <= side_ff[s-1];
      end
      for (int s = 8; s <= 12; s++) begin
         if (load[s]) q400_ff[s] <= q400_ff[s-1];
      end
      if (load[9]) c100_ff[9] <= h_q;
      for (int s = 10; s <= 12; s++) begin
         if (load[s]) c100_ff[s] <= c100_ff[s-1];
      end
      if (load[11]) q4_ff[11] <= f_q;
      if (load[12]) q4_ff[12] <= q4_ff[11];
   end

   // ---- year, leap flag and month ----
   logic                          leap_ff, leap_in;
   logic [YW-1:0]                 year_ff, year_in;
   logic [esc_pkg::MONTH_W-1:0]   mon_ff, mon_in;
   logic [esc_pkg::DOY_W-1:0]     doy_ff;

   // year - 1601 = 400*q400 + 100*c100 + 4*q4 + y1, so leap needs no divide
   assign leap_in = (y_q == 2'(esc_pkg::BLOCK_LAST)) &&
                    ((q4_ff[12] != 5'(esc_pkg::Q4_LAST_OF_CENTURY)) ||
                     (c100_ff[12] == 2'(esc_pkg::BLOCK_LAST)));

   assign year_in = YW'(q400_ff[12]) * YW'(esc_pkg::YEARS_PER_400Y)
                  + YW'(c100_ff[12]) * YW'(esc_pkg::YEARS_PER_100Y)
                  + YW'(q4_ff[12]) * YW'(esc_pkg::YEARS_PER_4Y)
                  + YW'(y_q)
                  - YW'(esc_pkg::YEAR_1601_TO_1900);

   always_comb begin
      mon_in = '0;
      for (int i = 1; i < esc_pkg::MONTHS; i++) begin
         if (y_r >= esc_pkg::MONTH_START[leap_in][i]) mon_in = mon_in + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load[13]) begin
         leap_ff <= leap_in;
         year_ff <= year_in;
         mon_ff  <= mon_in;
         doy_ff  <= y_r;
      end
   end

   // ---- output register ----
   logic [esc_pkg::MDAY_W-1:0]    mday_ff, mday_in;
   logic [esc_pkg::MONTH_W-1:0]   month_ff;
   logic [YW-1:0]                 years_ff;
   esc_pkg::side_type             out_side_ff;

   assign mday_in = esc_pkg::MDAY_W'(doy_ff - esc_pkg::MONTH_START[leap_ff][mon_ff]
                                     + 9'd1);

   always_ff @(posedge clock) begin
      if (load[14]) begin
         mday_ff     <= mday_in;
         month_ff    <= mon_ff;
         years_ff    <= year_ff;
         out_side_ff <= side_ff[13];
      end
   end

   assign rsp_second           = out_side_ff.second;
   assign rsp_minute           = out_side_ff.minute;
   assign rsp_hour             = out_side_ff.hour;
   assign rsp_weekday          = out_side_ff.weekday;
   assign rsp_day_of_month     = mday_ff;
   assign rsp_month_index      = month_ff;
   assign rsp_years_since_1900 = years_ff;

endmodule

/* bench/epoch_seconds_to_calendar_tb.sv */
// Self-checking bench for epoch_seconds_to_calendar: random and corner timestamps,
// random idling on both channels, every result checked against an in-bench calendar model.
// Depends on esc_pkg and the epoch_seconds_to_calendar RTL.
module epoch_seconds_to_calendar_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECS_W = esc_pkg::SECONDS_WIDTH_DEFAULT;
   localparam longint MAX_SECS = (longint'(1) << SECS_W) - 1;
   localparam longint MAX_DAY = MAX_SECS / 86400;
   localparam int CYCLE_LIMIT = 500000;
   localparam int TAIL_CYCLES = 30;

   typedef struct packed {
      logic [esc_pkg::SECOND_W-1:0]  second;
      logic [esc_pkg::MINUTE_W-1:0]  minute;
      logic [esc_pkg::HOUR_W-1:0]    hour;
      logic [esc_pkg::MDAY_W-1:0]    day_of_month;
      logic [esc_pkg::MONTH_W-1:0]   month_index;
      logic [esc_pkg::YEAR_W-1:0]    years_since_1900;
      logic [esc_pkg::WEEKDAY_W-1:0] weekday;
   } calendar_type;

   class calendar_scoreboard;
      calendar_type dates_due[$];
      int errors = 0;

      // Day count split into 400/100/4/1-year blocks from 1601-01-01.
      function calendar_type to_calendar(logic [SECS_W-1:0] stamp);
         longint unsigned secs, days, tod, d, q400, c100, q4, y1, year, mlen;
         int unsigned mon;
         bit leap;
         calendar_type c;
         secs = stamp;
         days = secs / 86400;
         tod = secs % 86400;
         c.second = 6'(tod % 60);
         c.minute = 6'((tod / 60) % 60);
         c.hour = 5'(tod / 3600);
         c.weekday = 3'((days + 4) % 7);    // 1970-01-01 was a Thursday
         d = days + 134774;
         q400 = d / 146097;
         d = d % 146097;
         c100 = d / 36524;
         if (c100 > 3) c100 = 3;
         d = d - c100 * 36524;
         q4 = d / 1461;
         d = d % 1461;
         y1 = d / 365;
         if (y1 > 3) y1 = 3;
         d = d - y1 * 365;
         year = 1601 + q400 * 400 + c100 * 100 + q4 * 4 + y1;
         leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
         mon = 0;
         while (mon < 11) begin
            if (mon == 1)
               mlen = leap ? 29 : 28;
            else if (mon == 3 || mon == 5 || mon == 8 || mon == 10)
               mlen = 30;
            else
               mlen = 31;
            if (d < mlen) break;
            d = d - mlen;
            mon++;
         end
         c.day_of_month = 5'(d + 1);
         c.month_index = 4'(mon);
         c.years_since_1900 = 10'(year - 1900);
         return c;
      endfunction

      function void note_seconds(logic [SECS_W-1:0] stamp);
         dates_due.push_back(to_calendar(stamp));
      endfunction

      function int pending();
         return dates_due.size();
      endfunction

      function void compare_field(string name, int unsigned expected, int unsigned actual);
         if (expected != actual) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
            errors++;
         end
      endfunction

      function void check_result(calendar_type got);
         calendar_type want;
         if (dates_due.size() == 0) begin
            $display("%0t: result with no transaction outstanding, got %p", $time, got);
            errors++;
            return;
         end
         want = dates_due.pop_front();
         compare_field("second", want.second, got.second);
         compare_field("minute", want.minute, got.minute);
         compare_field("hour", want.hour, got.hour);
         compare_field("day_of_month", want.day_of_month, got.day_of_month);
         compare_field("month_index", want.month_index, got.month_index);
         compare_field("years_since_1900", want.years_since_1900, got.years_since_1900);
         compare_field("weekday", want.weekday, got.weekday);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [SECS_W-1:0] req_epoch_seconds = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [esc_pkg::SECOND_W-1:0]  rsp_second;
   logic [esc_pkg::MINUTE_W-1:0]  rsp_minute;
   logic [esc_pkg::HOUR_W-1:0]    rsp_hour;
   logic [esc_pkg::MDAY_W-1:0]    rsp_day_of_month;
   logic [esc_pkg::MONTH_W-1:0]   rsp_month_index;
   logic [esc_pkg::YEAR_W-1:0]    rsp_years_since_1900;
   logic [esc_pkg::WEEKDAY_W-1:0] rsp_weekday;

   calendar_scoreboard sb;
   int cycles = 0;
   bit steady = 1'b0;

   epoch_seconds_to_calendar i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_second           (rsp_second),
      .rsp_minute           (rsp_minute),
      .rsp_hour             (rsp_hour),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_index      (rsp_month_index),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_weekday          (rsp_weekday)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_seconds(req_epoch_seconds);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_second, rsp_minute, rsp_hour, rsp_day_of_month,
                           rsp_month_index, rsp_years_since_1900, rsp_weekday});
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SECS_W-1:0] pick_seconds();
      logic [63:0] raw;
      longint v, day, y, n, off, tod;
      raw = {$urandom, $urandom};
      v = -1;
      case ($urandom_range(0, 3))
         0: v = raw[SECS_W-1:0];
         1: begin
            // midnight edges
            day = $urandom_range(0, int'(MAX_DAY));
            tod = $urandom_range(0, 1) ? 0 : 86399;
            if ($urandom_range(0, 3) == 0) tod = $urandom_range(0, 86399);
            v = day * 86400 + tod;
         end
         2: begin
            // around new year and the end of February, century years weighted up
            if ($urandom_range(0, 3) == 0)
               y = 2000 + 100 * longint'($urandom_range(0, 5));
            else
               y = $urandom_range(1970, 2513);
            n = y - 1;
            day = (y - 1970) * 365 + n / 4 - n / 100 + n / 400 - 477;
            case ($urandom_range(0, 5))
               0: off = -1;
               1: off = 0;
               2: off = 58;
               3: off = 59;
               4: off = 60;
               default: off = $urandom_range(300, 365);
            endcase
            tod = $urandom_range(0, 1) ? 86399 : $urandom_range(0, 86399);
            v = (day + off) * 86400 + tod;
         end
         default: v = $urandom;
      endcase
      if (v < 0 || v > MAX_SECS) v = raw[SECS_W-1:0];
      return v[SECS_W-1:0];
   endfunction

   task automatic send(logic [SECS_W-1:0] stamp, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= stamp;
      do @(posedge clock); while (req_stall);
   endtask

   // the first wait lets the monitor note the transaction accepted at this edge
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   // result-side backpressure
   initial begin
      int n;
      do @(posedge clock); while (reset);
      forever begin
         n = idle_cycles();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(50, 200)) @(posedge clock);
         else
            repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      logic [SECS_W-1:0] corners[$];
      sb = new();
      corners = '{
         '0, 34'd1, 34'd59, 34'd60, 34'd3599, 34'd3600, 34'd86399, 34'd86400,
         34'd31535999,        // last second of 1970
         34'd31536000,
         34'd68169600,        // 1972-02-29
         34'd951782400,       // 2000-02-29, leap by the 400 rule
         34'd978307199,       // last second of 2000, day 366
         34'd2147483647, 34'd4294967295, 34'd4294967296,
         34'd4107456000,      // 2100-02-28, century year not leap
         34'd4107542400,      // 2100-03-01
         34'd13574563200,     // 2400-02-29
         34'h2AAAAAAAA, 34'h155555555,
         {SECS_W{1'b1}}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (corners[i])
         send(corners[i], idle_cycles());

      for (int i = 0; i < 1230; i++) begin
         if (i % 150 == 0)
            steady = ($urandom_range(0, 2) == 0);
         if (i == 600)
            drain();
         send(pick_seconds(), steady ? 0 : idle_cycles());
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
